[rtl/tgfb_pkg.sv]
// ----------------------------------------------------------------------------
// tgfb_pkg: shared types, constants and font ROM
// Transaction payloads, queue command format and the 5x7 glyph table used by
// the text glyph frame buffer writer.
// ----------------------------------------------------------------------------
package tgfb_pkg;

	// defaults for the top-level parameters
	localparam int PANEL_WIDTH_DEF = 128;
	localparam int PANEL_PAGES_DEF = 8;

	// fixed geometry of the text engine
	localparam int ADDR_W       = 10;   // covers the largest panel (128 x 8)
	localparam int WRAP_LIMIT   = 122;
	localparam int GLYPH_COLS   = 5;
	localparam int CHAR_ADVANCE = 6;    // five glyph columns plus one gap
	localparam int QUEUE_DEPTH  = 2;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_SET   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_READ  = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] char_code;
		logic [6:0] column;
		logic [3:0] page_index;
	} req_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic [7:0] cursor_column;
		logic [3:0] cursor_page;
		logic       dropped;
	} rsp_t;

	// work for the back end; OP_NONE only returns the prepared response
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_WRITE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [7:0]        char_code;
		logic [7:0]        col;       // first column touched
		logic [ADDR_W-1:0] base;      // page * panel width
		rsp_t              rsp;       // cursor and drop flag already final
	} cmd_t;

	// glyph columns, leftmost first
	typedef logic [0:GLYPH_COLS-1][7:0] glyph_t;

	function automatic glyph_t glyph_cols(input logic [7:0] code);
		glyph_t g;
		unique case (code)
			8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
			8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
			8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
			8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
			8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
			8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
			8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
			8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
			8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
			8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
			8'h41: g = {8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E};
			8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
			8'h44: g = {8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
			8'h45: g = {8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
			8'h47: g = {8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
			8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
			8'h49: g = {8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
			8'h4A: g = {8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
			8'h4B: g = {8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
			8'h4C: g = {8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
			8'h4D: g = {8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F};
			8'h4E: g = {8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F};
			8'h4F: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
			8'h50: g = {8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
			8'h52: g = {8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
			8'h53: g = {8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
			8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
			8'h55: g = {8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
			8'h56: g = {8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
			8'h57: g = {8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
			8'h59: g = {8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
			8'h5A: g = {8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
			8'h61: g = {8'h20, 8'h54, 8'h54, 8'h54, 8'h78};
			8'h69: g = {8'h00, 8'h44, 8'h7D, 8'h40, 8'h00};
			8'h6E: g = {8'h7C, 8'h08, 8'h04, 8'h04, 8'h78};
			8'h6F: g = {8'h38, 8'h44, 8'h44, 8'h44, 8'h38};
			8'h70: g = {8'h7C, 8'h14, 8'h14, 8'h14, 8'h08};
			8'h73: g = {8'h48, 8'h54, 8'h54, 8'h54, 8'h20};
			8'h7A: g = {8'h44, 8'h64, 8'h54, 8'h4C, 8'h44};
			8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00};
			8'h3A: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00};
			8'h3D: g = {8'h14, 8'h14, 8'h14, 8'h14, 8'h14};
			8'h2D: g = {8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
			default: g = '0;   // unknown code draws blank
		endcase
		return g;
	endfunction

endpackage

[rtl/tgfb_front.sv]
// ----------------------------------------------------------------------------
// tgfb_front: request decode and cursor tracking
// Accepts request transactions, owns the cursor, and queues one command per
// request with its response fields already settled.
// ----------------------------------------------------------------------------
module tgfb_front import tgfb_pkg::*; #(
	parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
	parameter int PANEL_PAGES = PANEL_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	input  logic busy,
	input  logic full,
	output logic push,
	output cmd_t push_cmd
);

	logic [7:0] cur_x_q;
	logic [3:0] cur_pg_q;
	logic [7:0] nx_x;
	logic [3:0] nx_pg;
	logic [3:0] wrap_pg;
	logic       pg_out;
	logic       wrap_out;
	logic [2:0] sel_pg;

	assign req_ready = !busy && !full;
	assign push      = req_valid && req_ready;

	assign pg_out   = cur_pg_q >= 4'(PANEL_PAGES);
	assign wrap_pg  = cur_pg_q + 4'd1;
	assign wrap_out = wrap_pg >= 4'(PANEL_PAGES);

	always_comb begin
		nx_x            = cur_x_q;
		nx_pg           = cur_pg_q;
		sel_pg          = cur_pg_q[2:0];
		push_cmd.op        = OP_NONE;
		push_cmd.char_code = req.char_code;
		push_cmd.col       = cur_x_q;
		unique case (req.kind)
			KIND_WRITE: begin
				if (pg_out) begin
					// page already off the panel: nothing moves
				end else if (cur_x_q > 8'(WRAP_LIMIT)) begin
					nx_x  = '0;
					nx_pg = wrap_pg;
					if (!wrap_out) begin
						push_cmd.op  = OP_WRITE;
						push_cmd.col = '0;
						sel_pg       = wrap_pg[2:0];
						nx_x         = 8'(CHAR_ADVANCE);
					end
				end else begin
					push_cmd.op = OP_WRITE;
					nx_x        = cur_x_q + 8'(CHAR_ADVANCE);
				end
			end
			KIND_SET: begin
				nx_x  = {1'b0, req.column};
				nx_pg = req.page_index;
			end
			KIND_CLEAR: begin
				nx_x        = '0;
				nx_pg       = '0;
				push_cmd.op = OP_CLEAR;
			end
			KIND_READ: begin
				push_cmd.col = {1'b0, req.column};
				sel_pg       = req.page_index[2:0];
				if (req.page_index < 4'(PANEL_PAGES) && {1'b0, req.column} < 8'(PANEL_WIDTH))
					push_cmd.op = OP_READ;
			end
			default: ;
		endcase
		push_cmd.base              = ADDR_W'(sel_pg) * ADDR_W'(PANEL_WIDTH);
		push_cmd.rsp.read_byte     = '0;
		push_cmd.rsp.cursor_column = nx_x;
		push_cmd.rsp.cursor_page   = nx_pg;
		push_cmd.rsp.dropped       = (req.kind == KIND_WRITE) && (pg_out || (cur_x_q > 8'(WRAP_LIMIT) && wrap_out));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_pg_q <= '0;
		end else if (push) begin
			cur_x_q  <= nx_x;
			cur_pg_q <= nx_pg;
		end
	end

endmodule

[rtl/tgfb_queue.sv]
// ----------------------------------------------------------------------------
// tgfb_queue: command queue
// Small register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module tgfb_queue import tgfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

[rtl/tgfb_back.sv]
// ----------------------------------------------------------------------------
// tgfb_back: frame buffer engine
// Runs queued commands against the single-port pixel store: glyph writes,
// clear sweeps and byte reads, then loads the response register.
// ----------------------------------------------------------------------------
module tgfb_back import tgfb_pkg::*; #(
	parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
	parameter int PANEL_PAGES = PANEL_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	input  cmd_t head,
	output logic pop,
	output logic busy,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int DEPTH = PANEL_WIDTH * PANEL_PAGES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_WRITE = 6'b000100,
		ST_CLEAR = 6'b001000,
		ST_READ  = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	cmd_t              work_q;
	rsp_t              res_q;
	logic [7:0]        col_q;
	logic [2:0]        idx_q;
	logic [AW-1:0]     cnt_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [7:0]        store_q [DEPTH];
	logic [7:0]        rdata_q;
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [7:0]        mem_wdata;
	logic [ADDR_W-1:0] full_addr;
	glyph_t            glyph;
	logic              slot_free;

	assign busy      = state_q == ST_INIT;
	assign pop       = (state_q == ST_IDLE) && !empty;
	assign slot_free = !out_valid_q || rsp_ready;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;
	assign glyph     = glyph_cols(work_q.char_code);

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = '0;
		full_addr = '0;
		mem_addr  = cnt_q;
		unique case (state_q)
			ST_INIT, ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_WRITE: begin
				full_addr = work_q.base + ADDR_W'(col_q);
				mem_addr  = full_addr[AW-1:0];
				mem_we    = col_q < 8'(PANEL_WIDTH);
				mem_wdata = (idx_q == 3'(GLYPH_COLS)) ? 8'h00 : glyph[idx_q];
			end
			ST_IDLE: begin
				// read is issued while the command is taken off the queue
				full_addr = head.base + ADDR_W'(head.col);
				mem_addr  = full_addr[AW-1:0];
			end
			ST_READ, ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			store_q[mem_addr] <= mem_wdata;
		rdata_q <= store_q[mem_addr];
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= head;
			res_q  <= head.rsp;
			col_q  <= head.col;
			idx_q  <= '0;
		end else if (state_q == ST_WRITE) begin
			col_q <= col_q + 8'd1;
			idx_q <= idx_q + 3'd1;
		end else if (state_q == ST_READ) begin
			res_q.read_byte <= rdata_q;
		end
		if (state_q == ST_DONE && slot_free)
			out_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free)
				out_valid_q <= 1'b1;
			else if (rsp_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (!empty) begin
						unique case (head.op)
							OP_WRITE: state_q <= ST_WRITE;
							OP_CLEAR: state_q <= ST_CLEAR;
							OP_READ:  state_q <= ST_READ;
							OP_NONE:  state_q <= ST_DONE;
							default:  state_q <= ST_DONE;
						endcase
					end
				end
				ST_WRITE: begin
					if (idx_q == 3'(GLYPH_COLS))
						state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AW'(DEPTH - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DONE;
					end
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/text_glyph_framebuffer_writer.sv]
// ----------------------------------------------------------------------------
// text_glyph_framebuffer_writer: text-mode page frame buffer
// The back end works one command at a time: it takes the command off the queue,
// makes six single-port store writes per glyph, then loads the response register.
// Reset clears the cursor and the queue; the store is then swept to zero, one
// byte a cycle over all PANEL_WIDTH*PANEL_PAGES bytes, with req_ready held low.
// ----------------------------------------------------------------------------
//
// Structure:
//   tgfb_front  takes request transactions, keeps the cursor, works out wrap
//               and drop, and queues a command whose response fields are final
//               except for the read data.
//   tgfb_queue  two-entry FIFO; the front keeps accepting while a glyph is
//               still being drawn.
//   tgfb_back   owns the pixel store (page * PANEL_WIDTH + column). A glyph
//               is drawn as six store writes, leftmost column first, the last
//               one the blank gap; columns at or past the panel edge are skipped.
//               Clear sweeps every byte. Reads use the registered store port.
//               Responses wait in an output register, so a short response
//               stall does not reach the front; a longer one holds the back
//               end, fills the queue and then drops req_ready.
module text_glyph_framebuffer_writer import tgfb_pkg::*; #(
	parameter int PANEL_WIDTH = PANEL_WIDTH_DEF,
	parameter int PANEL_PAGES = PANEL_PAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	logic busy;
	logic full;
	logic empty;
	logic push;
	logic pop;
	cmd_t push_cmd;
	cmd_t head;

	tgfb_front #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_PAGES(PANEL_PAGES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.busy     (busy),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	tgfb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	tgfb_back #(
		.PANEL_WIDTH(PANEL_WIDTH),
		.PANEL_PAGES(PANEL_PAGES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.busy     (busy),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule
